// ===== rtl/via_pkg.sv =====
// ----------------------------------------------------------------------------
// Interface adapter package
// Commands, register map, flag bit positions and the packed stream payloads
// shared by the interface adapter.
// ----------------------------------------------------------------------------
package via_pkg;

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdRead  = 2'd1,
    CmdWrite = 2'd2,
    CmdLine  = 2'd3
  } via_cmd_e;

  typedef enum logic [3:0] {
    RegOrb   = 4'h0,
    RegOra   = 4'h1,
    RegDdrb  = 4'h2,
    RegDdra  = 4'h3,
    RegT1cl  = 4'h4,
    RegT1ch  = 4'h5,
    RegT1ll  = 4'h6,
    RegT1lh  = 4'h7,
    RegT2cl  = 4'h8,
    RegT2ch  = 4'h9,
    RegSr    = 4'ha,
    RegAcr   = 4'hb,
    RegPcr   = 4'hc,
    RegIfr   = 4'hd,
    RegIer   = 4'he,
    RegOraNh = 4'hf
  } via_reg_e;

  typedef enum logic [1:0] {
    LineCa1 = 2'd0,
    LineCa2 = 2'd1,
    LineCb1 = 2'd2,
    LineCb2 = 2'd3
  } via_line_e;

  localparam int unsigned FlagCa2 = 0;
  localparam int unsigned FlagCa1 = 1;
  localparam int unsigned FlagSr  = 2;
  localparam int unsigned FlagCb2 = 3;
  localparam int unsigned FlagCb1 = 4;
  localparam int unsigned FlagT2  = 5;
  localparam int unsigned FlagT1  = 6;

  localparam int unsigned NumFlags  = 7;
  localparam int unsigned CountW    = 18;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 24;

  // Last field in the lowest bits.
  typedef struct packed {
    logic [7:0] port_b_pins;
    logic [7:0] port_a_pins;
    logic       line_level;
    logic [1:0] line_select;
    logic [7:0] tick_cycles;
    logic [7:0] write_data;
    logic [3:0] reg_addr;
  } via_in_t;

  typedef struct packed {
    logic [7:0] irq_flags;
    logic       irq_request;
    logic [7:0] read_data;
  } via_out_t;

endpackage

// ===== rtl/versatile_interface_adapter.sv =====
// ----------------------------------------------------------------------------
// Versatile interface adapter
// Port, timer and interrupt registers of a 6522-style adapter, driven by one
// event per stream transfer.
// ----------------------------------------------------------------------------
// Each slave transfer carries one event: a timer tick of tick_cycles counts, a
// register read, a register write or a level change on CA1, CA2, CB1 or CB2.
// The kind of event travels in s_axis_tuser, its operands in s_axis_tdata.
// Every event yields exactly one master transfer with the read data (zero for
// all but reads), the interrupt request of this event and the flag register.
// An accepted event is held in the input register, where its whole effect on
// the registers is computed, and its result is loaded into the output register
// once that register is free or its result is being taken. One event is taken
// in every cycle as long as the receiver keeps up; the update of the timer,
// flag and port registers is computed combinationally from the input register.
// When the receiver stalls, the result holds in the output register and one
// more event may still wait in the input register; then s_axis_tready drops.
// Reset clears all port, timer, control and flag registers and empties both
// stages.
// ----------------------------------------------------------------------------
module versatile_interface_adapter import via_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // reg_addr, write_data, tick_cycles, line_select, line_level,
  // port_a_pins, port_b_pins, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // cmd
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // read_data, irq_request, irq_flags, zero fill
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic              in_valid_q;
  via_in_t           in_q;
  via_cmd_e          cmd_q;
  logic              out_valid_q;
  via_out_t          out_q, out_d;
  logic              advance;

  logic [7:0]        orb_q, orb_d, ora_q, ora_d, ddrb_q, ddrb_d, ddra_q, ddra_d;
  logic [15:0]       t1_latch_q, t1_latch_d, t2_latch_q, t2_latch_d;
  logic [CountW-1:0] t1_count_q, t1_count_d, t2_count_q, t2_count_d;
  logic              t1_armed_q, t1_armed_d, t2_armed_q, t2_armed_d;
  logic [7:0]        sr_q, sr_d, acr_q, acr_d, pcr_q, pcr_d;
  logic [NumFlags-1:0] ifr_q, ifr_d, ier_q, ier_d, set_bits, clr_bits;
  logic [3:0]        lines_q, lines_d;

  logic [CountW:0]   t1_dec, t2_dec;
  logic [CountW-1:0] t1_sub, t2_sub;
  logic [7:0]        port_a_rd, port_b_rd, rd_data;
  logic              line_edge;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign port_a_rd = (ora_q & ddra_q) | (in_q.port_a_pins & ~ddra_q);
  assign port_b_rd = (orb_q & ddrb_q) | (in_q.port_b_pins & ~ddrb_q);

  // Counts saturate at the most negative 18-bit value.
  assign t1_dec = {t1_count_q[CountW-1], t1_count_q} - {11'd0, in_q.tick_cycles};
  assign t2_dec = {t2_count_q[CountW-1], t2_count_q} - {11'd0, in_q.tick_cycles};
  assign t1_sub = (t1_dec[CountW:CountW-1] == 2'b10) ? {1'b1, {(CountW-1){1'b0}}}
                                                    : t1_dec[CountW-1:0];
  assign t2_sub = (t2_dec[CountW:CountW-1] == 2'b10) ? {1'b1, {(CountW-1){1'b0}}}
                                                    : t2_dec[CountW-1:0];

  assign line_edge = lines_q[in_q.line_select] != in_q.line_level;

  always_comb begin
    orb_d      = orb_q;
    ora_d      = ora_q;
    ddrb_d     = ddrb_q;
    ddra_d     = ddra_q;
    t1_latch_d = t1_latch_q;
    t2_latch_d = t2_latch_q;
    t1_count_d = t1_count_q;
    t2_count_d = t2_count_q;
    t1_armed_d = t1_armed_q;
    t2_armed_d = t2_armed_q;
    sr_d       = sr_q;
    acr_d      = acr_q;
    pcr_d      = pcr_q;
    ier_d      = ier_q;
    lines_d    = lines_q;
    set_bits   = '0;
    clr_bits   = '0;
    rd_data    = '0;
    case (cmd_q)
      CmdTick: begin
        if (t1_sub[CountW-1]) begin
          set_bits[FlagT1] = t1_armed_q;
          if (!acr_q[6]) begin
            t1_armed_d = 1'b0;
            t1_count_d = {2'b00, t1_sub[15:0]};
          end else begin
            t1_count_d = t1_sub + {2'b00, t1_latch_q} + 18'd2;
          end
        end else begin
          t1_count_d = t1_sub;
        end
        if (t2_sub[CountW-1]) begin
          set_bits[FlagT2] = t2_armed_q;
          t2_armed_d       = 1'b0;
          t2_count_d       = {2'b00, t2_sub[15:0]};
        end else begin
          t2_count_d = t2_sub;
        end
      end
      CmdRead: begin
        case (via_reg_e'(in_q.reg_addr))
          RegOrb: begin
            rd_data          = port_b_rd;
            clr_bits[FlagCb1] = 1'b1;
            clr_bits[FlagCb2] = (pcr_q[7:5] == 3'b000) || (pcr_q[7:5] == 3'b010);
          end
          RegOra: begin
            rd_data          = port_a_rd;
            clr_bits[FlagCa1] = 1'b1;
            clr_bits[FlagCa2] = (pcr_q[3:1] == 3'b000) || (pcr_q[3:1] == 3'b010);
          end
          RegDdrb: rd_data = ddrb_q;
          RegDdra: rd_data = ddra_q;
          RegT1cl: begin
            rd_data          = t1_count_q[7:0];
            clr_bits[FlagT1] = 1'b1;
          end
          RegT1ch: rd_data = t1_count_q[15:8];
          RegT1ll: rd_data = t1_latch_q[7:0];
          RegT1lh: rd_data = t1_latch_q[15:8];
          RegT2cl: begin
            rd_data          = t2_count_q[7:0];
            clr_bits[FlagT2] = 1'b1;
          end
          RegT2ch: rd_data = t2_count_q[15:8];
          RegSr: begin
            rd_data          = sr_q;
            clr_bits[FlagSr] = 1'b1;
          end
          RegAcr:  rd_data = acr_q;
          RegPcr:  rd_data = pcr_q;
          RegIfr:  rd_data = {|(ifr_q & ier_q), ifr_q};
          RegIer:  rd_data = {1'b1, ier_q};
          RegOraNh: rd_data = port_a_rd;
          default: rd_data = port_a_rd;
        endcase
      end
      CmdWrite: begin
        case (via_reg_e'(in_q.reg_addr))
          RegOrb: begin
            orb_d             = in_q.write_data;
            clr_bits[FlagCb1] = 1'b1;
            clr_bits[FlagCb2] = (pcr_q[7:5] == 3'b000) || (pcr_q[7:5] == 3'b010);
          end
          RegOra: begin
            ora_d             = in_q.write_data;
            clr_bits[FlagCa1] = 1'b1;
            clr_bits[FlagCa2] = (pcr_q[3:1] == 3'b000) || (pcr_q[3:1] == 3'b010);
          end
          RegDdrb: ddrb_d = in_q.write_data;
          RegDdra: ddra_d = in_q.write_data;
          RegT1cl, RegT1ll: t1_latch_d = {t1_latch_q[15:8], in_q.write_data};
          RegT1ch: begin
            t1_latch_d       = {in_q.write_data, t1_latch_q[7:0]};
            t1_count_d       = {2'b00, in_q.write_data, t1_latch_q[7:0]};
            t1_armed_d       = 1'b1;
            clr_bits[FlagT1] = 1'b1;
          end
          RegT1lh: begin
            t1_latch_d       = {in_q.write_data, t1_latch_q[7:0]};
            clr_bits[FlagT1] = 1'b1;
          end
          RegT2cl: t2_latch_d = {t2_latch_q[15:8], in_q.write_data};
          RegT2ch: begin
            t2_latch_d       = {in_q.write_data, t2_latch_q[7:0]};
            t2_count_d       = {2'b00, in_q.write_data, t2_latch_q[7:0]};
            t2_armed_d       = 1'b1;
            clr_bits[FlagT2] = 1'b1;
          end
          RegSr: begin
            sr_d             = in_q.write_data;
            clr_bits[FlagSr] = 1'b1;
          end
          RegAcr: acr_d = in_q.write_data;
          RegPcr: pcr_d = in_q.write_data;
          RegIfr: clr_bits = in_q.write_data[NumFlags-1:0];
          RegIer: begin
            if (in_q.write_data[7]) begin
              ier_d = ier_q | in_q.write_data[NumFlags-1:0];
            end else begin
              ier_d = ier_q & ~in_q.write_data[NumFlags-1:0];
            end
          end
          RegOraNh: ora_d = in_q.write_data;
          default: ora_d = in_q.write_data;
        endcase
      end
      CmdLine: begin
        lines_d[in_q.line_select] = in_q.line_level;
        if (line_edge) begin
          case (via_line_e'(in_q.line_select))
            LineCa1: set_bits[FlagCa1] = in_q.line_level == pcr_q[0];
            LineCa2: set_bits[FlagCa2] = in_q.line_level ? (pcr_q[3:2] == 2'b01)
                                                         : (pcr_q[3:2] == 2'b00);
            LineCb1: set_bits[FlagCb1] = in_q.line_level == pcr_q[4];
            LineCb2: set_bits[FlagCb2] = in_q.line_level ? (pcr_q[7:6] == 2'b01)
                                                         : (pcr_q[7:6] == 2'b00);
            default: set_bits = '0;
          endcase
        end
      end
      default: rd_data = '0;
    endcase
    ifr_d             = (ifr_q & ~clr_bits) | set_bits;
    out_d.read_data   = rd_data;
    out_d.irq_request = |(set_bits & ier_q);
    out_d.irq_flags   = {|(ifr_d & ier_d), ifr_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      orb_q       <= '0;
      ora_q       <= '0;
      ddrb_q      <= '0;
      ddra_q      <= '0;
      t1_latch_q  <= '0;
      t2_latch_q  <= '0;
      t1_count_q  <= '0;
      t2_count_q  <= '0;
      t1_armed_q  <= 1'b0;
      t2_armed_q  <= 1'b0;
      sr_q        <= '0;
      acr_q       <= '0;
      pcr_q       <= '0;
      ifr_q       <= '0;
      ier_q       <= '0;
      lines_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        orb_q       <= orb_d;
        ora_q       <= ora_d;
        ddrb_q      <= ddrb_d;
        ddra_q      <= ddra_d;
        t1_latch_q  <= t1_latch_d;
        t2_latch_q  <= t2_latch_d;
        t1_count_q  <= t1_count_d;
        t2_count_q  <= t2_count_d;
        t1_armed_q  <= t1_armed_d;
        t2_armed_q  <= t2_armed_d;
        sr_q        <= sr_d;
        acr_q       <= acr_d;
        pcr_q       <= pcr_d;
        ifr_q       <= ifr_d;
        ier_q       <= ier_d;
        lines_q     <= lines_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q  <= via_in_t'(s_axis_tdata[$bits(via_in_t)-1:0]);
      cmd_q <= via_cmd_e'(s_axis_tuser);
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(via_out_t)){1'b0}}, out_q};

  a_irq_implies_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_q.irq_request |-> out_q.irq_flags[7])
    else $error("interrupt request without summary flag");

  a_bus_access_sets_no_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (cmd_q == CmdRead || cmd_q == CmdWrite) |-> (ifr_d & ~ifr_q) == '0)
    else $error("register access raised an interrupt flag");

  a_t2_count_nonneg_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && cmd_q == CmdTick |=> !t2_count_q[CountW-1])
    else $error("timer 2 count negative after tick");

  a_t1_oneshot_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && cmd_q == CmdTick && !acr_q[6] |=> !t1_count_q[CountW-1])
    else $error("one-shot timer 1 count negative after tick");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Interface adapter testbench
// Drives register reads and writes, timer ticks and control line changes into
// the adapter with random gaps and receiver stalls, and checks every result
// transfer against a cycle-free shadow of the adapter registers.
// ----------------------------------------------------------------------------
package via_tb_pkg;
  import via_pkg::*;

  localparam logic [7:0] MaskCa2 = 8'(1 << FlagCa2);
  localparam logic [7:0] MaskCa1 = 8'(1 << FlagCa1);
  localparam logic [7:0] MaskSr  = 8'(1 << FlagSr);
  localparam logic [7:0] MaskCb2 = 8'(1 << FlagCb2);
  localparam logic [7:0] MaskCb1 = 8'(1 << FlagCb1);
  localparam logic [7:0] MaskT2  = 8'(1 << FlagT2);
  localparam logic [7:0] MaskT1  = 8'(1 << FlagT1);

  // CA2 and CB2 control field of the PCR.
  localparam logic [2:0] EdgeNeg    = 3'd0;
  localparam logic [2:0] EdgeNegInd = 3'd1;
  localparam logic [2:0] EdgePos    = 3'd2;
  localparam logic [2:0] EdgePosInd = 3'd3;

  localparam int CountFloor = -131072;

  class via_shadow;
    bit [7:0]  orb, ora, ddrb, ddra;
    bit [15:0] t1_latch, t2_latch;
    int        t1_count, t2_count;
    bit        t1_armed, t2_armed;
    bit [7:0]  sr, acr, pcr, ifr;
    bit [6:0]  ier;
    bit [3:0]  lines;
    bit        raised;
    via_out_t  expected_results[$];
    int        errors;

    function void settle();
      ifr[7] = |(ifr[6:0] & ier);
    endfunction

    function void raise_flags(logic [7:0] bits);
      ifr |= bits;
      if (|(bits[6:0] & ier)) raised = 1'b1;
      settle();
    endfunction

    function void drop_flags(logic [7:0] bits);
      ifr &= ~bits;
      settle();
    endfunction

    function int count_down(int c, int n);
      int r;
      r = c - n;
      return (r < CountFloor) ? CountFloor : r;
    endfunction

    function void clear_b_side();
      drop_flags(MaskCb1);
      if (pcr[7:5] == EdgeNeg || pcr[7:5] == EdgePos) drop_flags(MaskCb2);
    endfunction

    function void clear_a_side();
      drop_flags(MaskCa1);
      if (pcr[3:1] == EdgeNeg || pcr[3:1] == EdgePos) drop_flags(MaskCa2);
    endfunction

    function void tick_timers(int n);
      t1_count = count_down(t1_count, n);
      if (t1_count < 0) begin
        if (!acr[6]) begin
          if (t1_armed) begin
            raise_flags(MaskT1);
            t1_armed = 1'b0;
          end
          t1_count = t1_count & 32'h0000_ffff;
        end else begin
          if (t1_armed) raise_flags(MaskT1);
          t1_count = t1_count + int'(t1_latch) + 2;
        end
      end
      t2_count = count_down(t2_count, n);
      if (t2_count < 0) begin
        if (t2_armed) begin
          raise_flags(MaskT2);
          t2_armed = 1'b0;
        end
        t2_count = t2_count & 32'h0000_ffff;
      end
    endfunction

    function logic [7:0] read_register(via_reg_e addr, logic [7:0] pa, logic [7:0] pb);
      logic [31:0] c1, c2;
      c1 = t1_count;
      c2 = t2_count;
      case (addr)
        RegOrb: begin
          clear_b_side();
          return (orb & ddrb) | (pb & ~ddrb);
        end
        RegOra: begin
          clear_a_side();
          return (ora & ddra) | (pa & ~ddra);
        end
        RegDdrb: return ddrb;
        RegDdra: return ddra;
        RegT1cl: begin
          drop_flags(MaskT1);
          return c1[7:0];
        end
        RegT1ch: return c1[15:8];
        RegT1ll: return t1_latch[7:0];
        RegT1lh: return t1_latch[15:8];
        RegT2cl: begin
          drop_flags(MaskT2);
          return c2[7:0];
        end
        RegT2ch: return c2[15:8];
        RegSr: begin
          drop_flags(MaskSr);
          return sr;
        end
        RegAcr: return acr;
        RegPcr: return pcr;
        RegIfr: return ifr;
        RegIer: return {1'b1, ier};
        default: return (ora & ddra) | (pa & ~ddra);
      endcase
    endfunction

    function void write_register(via_reg_e addr, logic [7:0] v);
      case (addr)
        RegOrb: begin
          orb = v;
          clear_b_side();
        end
        RegOra: begin
          ora = v;
          clear_a_side();
        end
        RegDdrb: ddrb = v;
        RegDdra: ddra = v;
        RegT1cl, RegT1ll: t1_latch[7:0] = v;
        RegT1ch: begin
          t1_latch[15:8] = v;
          t1_count = int'(t1_latch);
          t1_armed = 1'b1;
          drop_flags(MaskT1);
        end
        RegT1lh: begin
          t1_latch[15:8] = v;
          drop_flags(MaskT1);
        end
        RegT2cl: t2_latch[7:0] = v;
        RegT2ch: begin
          t2_latch[15:8] = v;
          t2_count = int'(t2_latch);
          t2_armed = 1'b1;
          drop_flags(MaskT2);
        end
        RegSr: begin
          sr = v;
          drop_flags(MaskSr);
        end
        RegAcr: acr = v;
        RegPcr: pcr = v;
        RegIfr: begin
          ifr[6:0] = ifr[6:0] & ~v[6:0];
          settle();
        end
        RegIer: begin
          if (v[7]) ier = ier | v[6:0];
          else ier = ier & ~v[6:0];
          settle();
        end
        default: ora = v;
      endcase
    endfunction

    function void line_change(via_line_e sel, bit lvl);
      logic [2:0] m;
      if (lines[sel] == lvl) return;
      case (sel)
        LineCa1: if (lvl == pcr[0]) raise_flags(MaskCa1);
        LineCa2: begin
          m = pcr[3:1];
          if (lvl ? (m == EdgePos || m == EdgePosInd) : (m == EdgeNeg || m == EdgeNegInd))
            raise_flags(MaskCa2);
        end
        LineCb1: if (lvl == pcr[4]) raise_flags(MaskCb1);
        default: begin
          m = pcr[7:5];
          if (lvl ? (m == EdgePos || m == EdgePosInd) : (m == EdgeNeg || m == EdgeNegInd))
            raise_flags(MaskCb2);
        end
      endcase
      lines[sel] = lvl;
    endfunction

    function void take_event(via_cmd_e cmd, via_in_t ev);
      via_out_t res;
      res.read_data = 8'h00;
      raised = 1'b0;
      case (cmd)
        CmdTick: tick_timers(int'(ev.tick_cycles));
        CmdRead: res.read_data = read_register(via_reg_e'(ev.reg_addr), ev.port_a_pins,
                                               ev.port_b_pins);
        CmdWrite: write_register(via_reg_e'(ev.reg_addr), ev.write_data);
        default: line_change(via_line_e'(ev.line_select), ev.line_level);
      endcase
      settle();
      res.irq_request = raised;
      res.irq_flags = ifr;
      expected_results.push_back(res);
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
    endfunction

    function void check_result(via_out_t got);
      via_out_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %05h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      if (got.read_data !== want.read_data) report("read_data", want.read_data, got.read_data);
      if (got.irq_request !== want.irq_request)
        report("irq_request", 8'(want.irq_request), 8'(got.irq_request));
      if (got.irq_flags !== want.irq_flags) report("irq_flags", want.irq_flags, got.irq_flags);
    endfunction
  endclass
endpackage

module tb;
  import via_pkg::*;
  import via_tb_pkg::*;

  localparam int StallLimit = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = CmdTick;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [OutDataW-1:0] m_axis_tdata;

  via_shadow shadow = new();
  bit        steady;
  int        sink_left;
  int        quiet_cycles;

  versatile_interface_adapter u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic via_in_t random_fields();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(via_in_t)-1:0];
  endfunction

  always @(posedge clk_i) begin
    if (steady) begin
      m_axis_tready <= 1'b1;
    end else if (sink_left > 0) begin
      sink_left--;
    end else if (m_axis_tready) begin
      m_axis_tready <= 1'b0;
      sink_left = pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
      sink_left = $urandom_range(0, 15);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        shadow.take_event(via_cmd_e'(s_axis_tuser), via_in_t'(s_axis_tdata[$bits(via_in_t)-1:0]));
      if (m_axis_tvalid && m_axis_tready)
        shadow.check_result(via_out_t'(m_axis_tdata[$bits(via_out_t)-1:0]));
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_event(via_cmd_e cmd, via_in_t ev);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= InDataW'(ev);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= InDataW'({$urandom, $urandom});
      s_axis_tuser <= 2'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic reg_write(via_reg_e addr, logic [7:0] v);
    via_in_t ev;
    ev = random_fields();
    ev.reg_addr = addr;
    ev.write_data = v;
    push_event(CmdWrite, ev);
  endtask

  task automatic reg_read(via_reg_e addr, logic [7:0] pa, logic [7:0] pb);
    via_in_t ev;
    ev = random_fields();
    ev.reg_addr = addr;
    ev.port_a_pins = pa;
    ev.port_b_pins = pb;
    push_event(CmdRead, ev);
  endtask

  task automatic tick(logic [7:0] n);
    via_in_t ev;
    ev = random_fields();
    ev.tick_cycles = n;
    push_event(CmdTick, ev);
  endtask

  task automatic line_move(via_line_e sel, logic lvl);
    via_in_t ev;
    ev = random_fields();
    ev.line_select = sel;
    ev.line_level = lvl;
    push_event(CmdLine, ev);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (shadow.expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic directed_events();
    reg_read(RegIer, 8'h00, 8'hff);
    reg_write(RegIer, 8'hff);
    reg_write(RegDdra, 8'hf0);
    reg_write(RegOra, 8'h5a);
    reg_read(RegOra, 8'h00, 8'h00);
    reg_read(RegOraNh, 8'hff, 8'hff);
    reg_read(RegOrb, 8'h00, 8'hff);
    reg_write(RegT1cl, 8'h00);
    reg_write(RegT1ch, 8'h00);
    tick(8'hff);
    reg_read(RegT1cl, 8'h00, 8'h00);
    reg_write(RegAcr, 8'h40);
    reg_write(RegT1ch, 8'h00);
    tick(8'hff);
    tick(8'h00);
    reg_write(RegIfr, 8'h7f);
    reg_write(RegT2cl, 8'hff);
    reg_write(RegT2ch, 8'h00);
    tick(8'hff);
    tick(8'h01);
    reg_write(RegPcr, 8'h01);
    line_move(LineCa1, 1'b1);
    line_move(LineCa1, 1'b1);
    reg_write(RegIer, 8'h7f);
    reg_read(RegIfr, 8'h00, 8'h00);
  endtask

  task automatic random_events(int count);
    via_in_t  ev;
    via_cmd_e cmd;
    int       r;
    for (int i = 0; i < count; i++) begin
      steady = (i % 50) >= 40;
      ev = random_fields();
      r = $urandom_range(0, 99);
      if (r < 30) begin
        cmd = CmdTick;
        if ($urandom_range(0, 3) != 0) ev.tick_cycles = 8'($urandom_range(0, 8));
      end else if (r < 55) begin
        cmd = CmdRead;
      end else if (r < 85) begin
        cmd = CmdWrite;
        if ((ev.reg_addr == RegT1ch || ev.reg_addr == RegT2ch || ev.reg_addr == RegT1lh)
            && $urandom_range(0, 3) != 0)
          ev.write_data = 8'($urandom_range(0, 1));
      end else begin
        cmd = CmdLine;
      end
      push_event(cmd, ev);
    end
    steady = 1'b0;
  endtask

  // Free-running timer 1 with a zero latch loses 253 counts per full tick and
  // reaches the count floor after a little over 500 ticks.
  task automatic timer_floor_run();
    reg_write(RegAcr, 8'h40 | 8'($urandom_range(0, 255)));
    reg_write(RegT1cl, 8'h00);
    reg_write(RegT1ch, 8'h00);
    for (int i = 0; i < 600; i++) begin
      if (i % 10 == 9) reg_read(($urandom_range(0, 1) != 0) ? RegT1cl : RegT1ch,
                                8'($urandom), 8'($urandom));
      else tick(8'hff);
    end
    reg_write(RegAcr, 8'h00);
    tick(8'h00);
    reg_read(RegT1cl, 8'h00, 8'h00);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_events();
    drain_results();
    random_events(60);
    timer_floor_run();
    drain_results();
    random_events(60);
    drain_results();
    repeat (10) @(posedge clk_i);
    if (shadow.errors == 0 && shadow.expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
